[design/ptt_pkg.sv]
package ptt_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int SLOTS_USED = (MAX_TASKS < 16) ? MAX_TASKS : 16;
    localparam int IDX_W      = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;
    localparam int SLOT_W     = 4;
    localparam int IVAL_W     = 16;
    localparam int SEC_W      = 32;
    localparam int DUE_W      = SEC_W + 1;
    localparam int US_W       = 20;
    localparam int PC_W       = 3;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHANGE = 2'd2,
        OP_TIME   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_UNKNOWN = 2'd2,
        KIND_DUE     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        UOP_WAIT  = 3'd0,
        UOP_CMD   = 3'd1,
        UOP_PRIME = 3'd2,
        UOP_SCAN  = 3'd3,
        UOP_FLUSH = 3'd4
    } t_uop;

    typedef enum logic [1:0] {
        COND_NEXT   = 2'd0,
        COND_ALWAYS = 2'd1,
        COND_IDLE   = 2'd2,
        COND_MORE   = 2'd3
    } t_cond;

    typedef struct packed {
        t_uop             uop;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic [IVAL_W-1:0] interval;
        logic [DUE_W-1:0]  due_s;
        logic [US_W-1:0]   due_us;
    } t_entry;

    localparam logic [PC_W-1:0] PC_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] PC_CMD   = 3'd1;
    localparam logic [PC_W-1:0] PC_PRIME = 3'd2;
    localparam logic [PC_W-1:0] PC_SCAN  = 3'd3;
    localparam logic [PC_W-1:0] PC_FLUSH = 3'd4;

    // control store
    function automatic t_uword ucode(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_WAIT:  w = '{uop: UOP_WAIT,  cond: COND_IDLE,   target: PC_WAIT};
            PC_CMD:   w = '{uop: UOP_CMD,   cond: COND_NEXT,   target: PC_WAIT};
            PC_PRIME: w = '{uop: UOP_PRIME, cond: COND_NEXT,   target: PC_WAIT};
            PC_SCAN:  w = '{uop: UOP_SCAN,  cond: COND_MORE,   target: PC_SCAN};
            PC_FLUSH: w = '{uop: UOP_FLUSH, cond: COND_ALWAYS, target: PC_WAIT};
            default:  w = '{uop: UOP_WAIT,  cond: COND_ALWAYS, target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

[design/ptt_ram.sv]
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/periodic_timer_table.sv]
// Table of up to sixteen periodic timers run against an external time base.
// Each request (add, remove, change interval, new time) yields an acknowledge
// or error result, then one due result for every valid slot whose next time
// has been reached, in ascending slot order; the final result of a request
// carries o_last. A request passes through an accept step, a command step,
// a step that primes the slot memory read, a scan step for each slot
// (SLOTS_USED slots) and a closing step. The scan steps through the slots
// over the single read port of the slot memory and holds while a due result
// waits on the result side. A new request is taken while the closing result
// still waits in the output register.
module periodic_timer_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  ptt_pkg::t_opcode                i_opcode,
    input  logic [ptt_pkg::SLOT_W-1:0]      i_task_slot,
    input  logic [ptt_pkg::IVAL_W-1:0]      i_interval_seconds,
    input  logic [ptt_pkg::SEC_W-1:0]       i_time_seconds,
    input  logic [ptt_pkg::US_W-1:0]        i_time_micros,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output ptt_pkg::t_kind                  o_result_kind,
    output logic [ptt_pkg::SLOT_W-1:0]      o_result_slot,
    output logic                            o_last
);
    import ptt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS_USED - 1);

    logic [PC_W-1:0]   r_pc, n_pc;
    t_uword            uw;

    t_opcode           r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [IVAL_W-1:0] r_ival;
    logic [SEC_W-1:0]  r_tsec;
    logic [US_W-1:0]   r_tus;

    logic [SEC_W-1:0]  r_now_s;
    logic [US_W-1:0]   r_now_us;
    logic [SLOTS_USED-1:0] r_valid;
    logic [IDX_W-1:0]  r_idx;

    t_kind             r_hold_kind;
    logic [SLOT_W-1:0] r_hold_slot;
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_last;

    logic              accept, out_free, stall, cond_true;
    logic              id_ok, free_found, scan_due, reached;
    logic [IDX_W-1:0]  free_idx, id_idx;
    logic [IVAL_W-1:0] sched_ival;
    logic [DUE_W-1:0]  sched_due, now_ext;
    t_entry            rd_e, wr_e;
    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;

    assign uw          = ucode(r_pc);
    assign o_req_ready = (uw.uop == UOP_WAIT);
    assign accept      = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_res_ready;

    assign id_idx = r_slot[IDX_W-1:0];
    assign id_ok  = ({1'b0, r_slot} < (SLOT_W + 1)'(SLOTS_USED)) && r_valid[id_idx];

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = SLOTS_USED - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(s);
            end
        end
    end

    assign now_ext  = {1'b0, r_now_s};
    assign reached  = (now_ext > rd_e.due_s) ||
                      ((now_ext == rd_e.due_s) && (r_now_us >= rd_e.due_us));
    assign scan_due = r_valid[r_idx] && reached;

    assign stall = ((uw.uop == UOP_SCAN) && scan_due && !out_free) ||
                   ((uw.uop == UOP_FLUSH) && !out_free);

    always_comb begin
        case (uw.cond)
            COND_NEXT:   cond_true = 1'b0;
            COND_ALWAYS: cond_true = 1'b1;
            COND_IDLE:   cond_true = !accept;
            COND_MORE:   cond_true = (r_idx != LAST_IDX);
            default:     cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            n_pc = r_pc;
        end else if (cond_true) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    // shared rescheduling adder
    assign sched_ival = (uw.uop == UOP_SCAN) ? rd_e.interval : r_ival;
    assign sched_due  = DUE_W'(r_now_s) + DUE_W'(sched_ival);

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        raddr = '0;
        wr_e  = '{interval: sched_ival, due_s: sched_due, due_us: r_now_us};
        case (uw.uop)
            UOP_CMD: begin
                if (r_op == OP_ADD && free_found) begin
                    we    = 1'b1;
                    waddr = free_idx;
                end else if (r_op == OP_CHANGE && id_ok) begin
                    we    = 1'b1;
                    waddr = id_idx;
                end
            end
            UOP_SCAN: begin
                we    = scan_due && !stall;
                waddr = r_idx;
                raddr = (!stall && r_idx != LAST_IDX) ? r_idx + 1'b1 : r_idx;
            end
            default: begin
            end
        endcase
    end

    ptt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS_USED)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_e),
        .i_raddr (raddr),
        .o_rdata (rd_e)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_opcode;
            r_slot <= i_task_slot;
            r_ival <= i_interval_seconds;
            r_tsec <= i_time_seconds;
            r_tus  <= i_time_micros;
        end
        case (uw.uop)
            UOP_CMD: begin
                case (r_op)
                    OP_ADD: begin
                        r_hold_kind <= free_found ? KIND_ACK : KIND_FULL;
                        r_hold_slot <= free_found ? SLOT_W'(free_idx) : '0;
                    end
                    OP_REMOVE, OP_CHANGE: begin
                        r_hold_kind <= id_ok ? KIND_ACK : KIND_UNKNOWN;
                        r_hold_slot <= '0;
                    end
                    default: begin
                        r_hold_kind <= KIND_ACK;
                        r_hold_slot <= '0;
                    end
                endcase
            end
            UOP_SCAN: begin
                if (scan_due && !stall) begin
                    r_hold_kind <= KIND_DUE;
                    r_hold_slot <= SLOT_W'(r_idx);
                end
            end
            default: begin
            end
        endcase
        if ((uw.uop == UOP_SCAN && scan_due && !stall) ||
            (uw.uop == UOP_FLUSH && !stall)) begin
            r_out_kind <= r_hold_kind;
            r_out_slot <= r_hold_slot;
            r_out_last <= (uw.uop == UOP_FLUSH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_valid     <= '0;
            r_now_s     <= '0;
            r_now_us    <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            case (uw.uop)
                UOP_CMD: begin
                    if (r_op == OP_ADD && free_found) begin
                        r_valid[free_idx] <= 1'b1;
                    end else if (r_op == OP_REMOVE && id_ok) begin
                        r_valid[id_idx] <= 1'b0;
                    end else if (r_op == OP_TIME) begin
                        r_now_s  <= r_tsec;
                        r_now_us <= r_tus;
                    end
                end
                UOP_PRIME: r_idx <= '0;
                UOP_SCAN: begin
                    if (!stall && r_idx != LAST_IDX) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if ((uw.uop == UOP_SCAN && scan_due && !stall) ||
                (uw.uop == UOP_FLUSH && !stall)) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_result_slot = r_out_slot;
    assign o_last        = r_out_last;

    a_accept_to_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_pc == PC_CMD))
        else $error("request accept not followed by command step");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.uop == UOP_FLUSH && out_free) |=> (r_out_valid && r_out_last && r_pc == PC_WAIT))
        else $error("closing result missing last flag");

    a_due_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_DUE) |->
            ({1'b0, r_out_slot} < (SLOT_W + 1)'(SLOTS_USED)))
        else $error("due result names slot beyond table");

    a_scan_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.uop == UOP_SCAN && stall) |=> ($stable(r_idx) && r_pc == PC_SCAN))
        else $error("scan moved while result side stalled");

    a_ready_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.uop == UOP_SCAN) |-> !o_req_ready)
        else $error("request taken during scan");

endmodule
